// ===== src/qtg_pkg.sv =====
// ----------------------------------------------------------------------------
// qtg_pkg : queued tone generator shared definitions
// Widths, register codes, queue sizes, the ms-to-samples reciprocal and the
// quarter-wave sine magnitude table built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package qtg_pkg;

    // Note queue depth (2..31) and sine table length (power of two, 64..4096)
    localparam int QUEUE_DEPTH  = 16;
    localparam int SINE_ENTRIES = 1024;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SINE_W  = $clog2(SINE_ENTRIES);
    localparam int SINE_QTR = SINE_ENTRIES / 4;
    localparam int QTR_W   = SINE_W - 2;

    // Field widths
    localparam int AMP_W    = 15;
    localparam int RATE_W   = 17;
    localparam int STEP_W   = 32;
    localparam int DUR_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int PEND_W   = 5;
    localparam int REM_W    = 23;
    localparam int NOTE_W   = STEP_W + REM_W;

    localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd28000;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;
    localparam logic [REM_W-1:0]  REM_MAX    = '1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;

    // Operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // samples = (dur * rate) / 1000 = ((dur * rate) >> 3) / 125,
    // the /125 done as a multiply by ceil(2^37 / 125), exact below 2^30
    localparam int PROD_W      = DUR_W + RATE_W;
    localparam int DIV_PRE     = 3;
    localparam int QIN_W       = PROD_W - DIV_PRE;
    localparam int RECIP_SHIFT = 37;
    localparam int RECIP_W     = 31;
    localparam longint unsigned RECIP_FULL = ((64'd1 << RECIP_SHIFT) + 64'd124) / 64'd125;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int SCALED_W    = QIN_W + RECIP_W;
    localparam int QUOT_W      = SCALED_W - RECIP_SHIFT;

    // Decoupling queues
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int CMDQ_FILL_W = CMDQ_CNT_W + 1;
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_IDX_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int OUTQ_FILL_W = OUTQ_CNT_W + 1;

    // Sine magnitude, Q30
    localparam int Q_FRAC = 30;
    localparam int S_W    = 31;
    localparam int MAG_W  = SAMPLE_W - 1;
    localparam longint unsigned Q30_ONE     = 64'h4000_0000;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic              op;
        logic [STEP_W-1:0] step;
        logic [REM_W-1:0]  count;
    } t_cmd;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [REM_W-1:0]  count;
    } t_note;

    typedef struct packed {
        logic              sound;
        logic [SINE_W-1:0] index;
        logic              accepted;
        logic [PEND_W-1:0] pending;
    } t_voice;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       accepted;
        logic [PEND_W-1:0]          pending;
    } t_result;

    typedef logic [S_W-1:0] t_sine_rom [SINE_QTR];

    // Taylor series to x^11, Horner form, truncating at every step.
    // j is the quarter-wave position, 0 .. SINE_QTR.
    function automatic logic [S_W-1:0] sine_mag(input int j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned p;
        longint unsigned s;
        x  = (64'(j) * 64'd4 * HALF_PI_Q30) / SINE_ENTRIES;
        x2 = (x * x) >> Q_FRAC;
        t  = Q30_ONE - x2 / 64'd110;
        p  = ((x2 * t) >> Q_FRAC) / 64'd72;
        t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p  = ((x2 * t) >> Q_FRAC) / 64'd42;
        t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p  = ((x2 * t) >> Q_FRAC) / 64'd20;
        t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        p  = ((x2 * t) >> Q_FRAC) / 64'd6;
        t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        s  = (x * t) >> Q_FRAC;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return S_W'(s);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int j = 0; j < SINE_QTR; j++) begin
            rom[j] = sine_mag(j);
        end
        return rom;
    endfunction

    localparam t_sine_rom      SINE_ROM  = build_sine_rom();
    localparam logic [S_W-1:0] SINE_PEAK = sine_mag(SINE_QTR);

endpackage

`default_nettype wire

// ===== src/qtg_ram.sv =====
// ----------------------------------------------------------------------------
// qtg_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/qtg_front.sv =====
// ----------------------------------------------------------------------------
// qtg_front : input acceptance and note length conversion
// Two-stage pipeline turning a duration in ms into a saturated sample count.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_front
    import qtg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output      logic                  o_full,
    input  wire logic                  i_operation,
    input  wire logic [STEP_W-1:0]     i_phase_step,
    input  wire logic [DUR_W-1:0]      i_duration_ms,
    input  wire logic [RATE_W-1:0]     i_sample_rate,
    input  wire logic [CMDQ_CNT_W-1:0] i_cmdq_count,
    output      logic                  o_cmd_valid,
    output      t_cmd                  o_cmd
);

    logic                   r_f1_valid;
    logic                   r_f1_op;
    logic [STEP_W-1:0]      r_f1_step;
    logic [PROD_W-1:0]      r_f1_prod;
    logic                   r_f2_valid;
    logic                   r_f2_op;
    logic [STEP_W-1:0]      r_f2_step;
    logic [QUOT_W-1:0]      r_f2_quot;
    logic [SCALED_W-1:0]    scaled;
    logic [CMDQ_FILL_W-1:0] fill;
    logic                   accept;

    // room is reserved for everything still in the two stages
    assign fill = CMDQ_FILL_W'(i_cmdq_count) + CMDQ_FILL_W'(r_f1_valid)
                + CMDQ_FILL_W'(r_f2_valid);
    assign o_full = fill >= CMDQ_FILL_W'(CMDQ_DEPTH);
    assign accept = i_push && !o_full;

    assign scaled = SCALED_W'(r_f1_prod[PROD_W-1:DIV_PRE]) * SCALED_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_op   <= i_operation;
        r_f1_step <= i_phase_step;
        r_f1_prod <= PROD_W'(i_duration_ms) * PROD_W'(i_sample_rate);
        r_f2_op   <= r_f1_op;
        r_f2_step <= r_f1_step;
        r_f2_quot <= scaled[SCALED_W-1:RECIP_SHIFT];
    end

    assign o_cmd_valid = r_f2_valid;
    assign o_cmd.op    = r_f2_op;
    assign o_cmd.step  = r_f2_step;
    assign o_cmd.count = (r_f2_quot > QUOT_W'(REM_MAX)) ? REM_MAX : r_f2_quot[REM_W-1:0];

endmodule

`default_nettype wire

// ===== src/qtg_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// qtg_cmd_queue : command queue between front and player
// Small register FIFO; the front reserves space through the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_cmd_queue
    import qtg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_pop,
    output      logic                  o_valid,
    output      t_cmd                  o_cmd,
    output      logic [CMDQ_CNT_W-1:0] o_count
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_IDX_W-1:0] r_wr_ptr;
    logic [CMDQ_IDX_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== src/qtg_player.sv =====
// ----------------------------------------------------------------------------
// qtg_player : note queue and phase accumulator
// Executes one command per cycle unless the synth is full; the playing note
// sits in registers and the note after it is read ahead from the note RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_player
    import qtg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output      logic o_cmd_pop,
    input  wire logic i_voice_ready,
    output      logic o_voice_valid,
    output      t_voice o_voice
);

    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [STEP_W-1:0] r_phase;
    logic [STEP_W-1:0] r_cur_step;
    logic [REM_W-1:0]  r_cur_rem;
    logic              r_byp_sel;
    t_note             r_byp;

    logic [IDX_W-1:0]  n_head;
    logic [CNT_W-1:0]  n_count;
    logic [STEP_W-1:0] n_cur_step;
    logic [REM_W-1:0]  n_cur_rem;
    logic [IDX_W-1:0]  rd_addr;
    logic [NOTE_W-1:0] rd_data;
    t_note             wr_note;
    t_note             nxt;
    logic              issue;
    logic              store;
    logic              play;
    logic              last;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign issue     = i_cmd_valid && i_voice_ready;
    assign o_cmd_pop = issue;

    assign store = issue && (i_cmd.op == OP_ENQUEUE) && (i_cmd.count != '0)
                && (r_count < CNT_W'(QUEUE_DEPTH));
    assign play  = issue && (i_cmd.op == OP_TICK) && (r_count != '0);
    assign last  = r_cur_rem == REM_W'(1);

    assign wr_note.step  = i_cmd.step;
    assign wr_note.count = i_cmd.count;

    // the RAM always reads the slot after the (next) head
    assign nxt     = r_byp_sel ? r_byp : t_note'(rd_data);
    assign n_head  = (play && last) ? next_idx(r_head) : r_head;
    assign rd_addr = next_idx(n_head);

    always_comb begin
        n_count    = r_count;
        n_cur_step = r_cur_step;
        n_cur_rem  = r_cur_rem;
        if (store) begin
            n_count = r_count + 1'b1;
            if (r_count == '0) begin
                n_cur_step = i_cmd.step;
                n_cur_rem  = i_cmd.count;
            end
        end else if (play) begin
            if (last) begin
                n_count    = r_count - 1'b1;
                n_cur_step = nxt.step;
                n_cur_rem  = nxt.count;
            end else begin
                n_cur_rem = r_cur_rem - 1'b1;
            end
        end
    end

    qtg_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_note_ram (
        .i_clk     (i_clk),
        .i_wr_en   (store),
        .i_wr_addr (r_tail),
        .i_wr_data (wr_note),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_phase       <= '0;
            r_byp_sel     <= 1'b0;
            o_voice_valid <= 1'b0;
        end else begin
            r_head        <= n_head;
            r_count       <= n_count;
            o_voice_valid <= issue;
            // a write landing on the slot being read ahead is forwarded
            r_byp_sel     <= store && (r_tail == rd_addr);
            if (store) begin
                r_tail <= next_idx(r_tail);
            end
            if (play) begin
                r_phase <= r_phase + r_cur_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_step       <= n_cur_step;
        r_cur_rem        <= n_cur_rem;
        r_byp            <= wr_note;
        o_voice.sound    <= play;
        o_voice.index    <= r_phase[STEP_W-1 -: SINE_W];
        o_voice.accepted <= store;
        o_voice.pending  <= PEND_W'(n_count);
    end

endmodule

`default_nettype wire

// ===== src/qtg_synth.sv =====
// ----------------------------------------------------------------------------
// qtg_synth : sine lookup, amplitude scaling and result queue
// Quarter-wave table read, one 15x31 multiply, then a register FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_synth
    import qtg_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [AMP_W-1:0]           i_amplitude,
    input  wire logic                       i_voice_valid,
    input  wire t_voice                     i_voice,
    output      logic                       o_voice_ready,
    output      logic                       o_empty,
    input  wire logic                       i_pop,
    output      logic signed [SAMPLE_W-1:0] o_sample,
    output      logic                       o_accepted,
    output      logic [PEND_W-1:0]          o_pending
);

    logic                  r_s2_valid;
    logic                  r_s2_sound;
    logic                  r_s2_neg;
    logic [S_W-1:0]        r_s2_mag;
    logic                  r_s2_accepted;
    logic [PEND_W-1:0]     r_s2_pending;
    logic                  r_s3_valid;
    logic                  r_s3_sound;
    logic                  r_s3_neg;
    logic [MAG_W-1:0]      r_s3_mag;
    logic                  r_s3_accepted;
    logic [PEND_W-1:0]     r_s3_pending;

    t_result               r_mem [OUTQ_DEPTH];
    logic [OUTQ_IDX_W-1:0] r_wr_ptr;
    logic [OUTQ_IDX_W-1:0] r_rd_ptr;
    logic [OUTQ_CNT_W-1:0] r_count;

    logic [1:0]             quadrant;
    logic [QTR_W-1:0]       pos;
    logic [QTR_W-1:0]       mirror;
    logic [S_W-1:0]         s_lookup;
    logic [AMP_W+S_W-1:0]   prod;
    logic [SAMPLE_W-1:0]    scaled;
    logic signed [SAMPLE_W-1:0] wr_sample;
    t_result                wr_result;
    logic [OUTQ_FILL_W-1:0] fill;
    logic                   pop;

    // results in flight are counted against the queue space
    assign fill = OUTQ_FILL_W'(r_count) + OUTQ_FILL_W'(i_voice_valid)
                + OUTQ_FILL_W'(r_s2_valid) + OUTQ_FILL_W'(r_s3_valid);
    assign o_voice_ready = fill < OUTQ_FILL_W'(OUTQ_DEPTH);

    // odd quadrants run the table backwards; -pos is SINE_QTR - pos
    assign quadrant = i_voice.index[SINE_W-1 -: 2];
    assign pos      = i_voice.index[QTR_W-1:0];
    assign mirror   = (~pos) + 1'b1;

    always_comb begin
        if (!quadrant[0]) begin
            s_lookup = SINE_ROM[pos];
        end else if (pos == '0) begin
            s_lookup = SINE_PEAK;
        end else begin
            s_lookup = SINE_ROM[mirror];
        end
    end

    assign prod   = (AMP_W+S_W)'(i_amplitude) * (AMP_W+S_W)'(r_s2_mag);
    assign scaled = prod[AMP_W+S_W-1:Q_FRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_voice_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_sound    <= i_voice.sound;
        r_s2_neg      <= quadrant[1];
        r_s2_mag      <= s_lookup;
        r_s2_accepted <= i_voice.accepted;
        r_s2_pending  <= i_voice.pending;
        r_s3_sound    <= r_s2_sound;
        r_s3_neg      <= r_s2_neg;
        r_s3_mag      <= scaled[SAMPLE_W-1] ? '1 : scaled[MAG_W-1:0];
        r_s3_accepted <= r_s2_accepted;
        r_s3_pending  <= r_s2_pending;
    end

    always_comb begin
        if (!r_s3_sound) begin
            wr_sample = '0;
        end else if (r_s3_neg) begin
            wr_sample = -$signed(SAMPLE_W'(r_s3_mag));
        end else begin
            wr_sample = $signed(SAMPLE_W'(r_s3_mag));
        end
    end

    assign wr_result.sample   = wr_sample;
    assign wr_result.accepted = r_s3_accepted;
    assign wr_result.pending  = r_s3_pending;

    assign pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            r_mem[r_wr_ptr] <= wr_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_s3_valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (r_s3_valid && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!r_s3_valid && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_empty    = r_count == '0;
    assign o_sample   = r_mem[r_rd_ptr].sample;
    assign o_accepted = r_mem[r_rd_ptr].accepted;
    assign o_pending  = r_mem[r_rd_ptr].pending;

endmodule

`default_nettype wire

// ===== src/queued_tone_generator_unit.sv =====
// ----------------------------------------------------------------------------
// queued_tone_generator_unit : note queue driving a sine oscillator
// Enqueue transactions store notes; tick transactions yield one sample each.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   input    | in        | i_push / o_full        | i_operation, i_phase_step,
//            |           |                        | i_duration_ms
//   result   | out       | o_empty / i_pop        | o_sample, o_accepted, o_pending
//   config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One transaction per clock sustained on both queue sides if i_pop keeps up.
// Between acceptance and the result showing on the ports lie
// two front stages (ms to samples multiplies), the command queue, the player
// update, the sine table read and the amplitude multiply, then the result queue.
// The playing note sits in registers and the note RAM reads the following note
// ahead every cycle, so note changes do not stall the player.
// Reset is synchronous; the note RAM is not cleared.
// Either side may stall freely: the command and result queues keep credits
// for every transaction still in flight.
`default_nettype none

module queued_tone_generator_unit
    import qtg_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input queue side
    input  wire logic                       i_push,
    output      logic                       o_full,
    input  wire logic                       i_operation,
    input  wire logic [STEP_W-1:0]          i_phase_step,
    input  wire logic [DUR_W-1:0]           i_duration_ms,
    // result queue side
    output      logic                       o_empty,
    input  wire logic                       i_pop,
    output      logic signed [SAMPLE_W-1:0] o_sample,
    output      logic                       o_accepted,
    output      logic [PEND_W-1:0]          o_pending,
    // configuration writes
    input  wire logic                       i_cfg_valid,
    output      logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data
);

    // configuration registers
    logic [AMP_W-1:0]  r_amplitude;
    logic [RATE_W-1:0] r_sample_rate;

    // front -> command queue -> player -> synth
    logic                  cmd_push;
    t_cmd                  cmd_in;
    logic                  cmd_valid;
    t_cmd                  cmd_head;
    logic                  cmd_pop;
    logic [CMDQ_CNT_W-1:0] cmd_count;
    logic                  voice_valid;
    t_voice                voice;
    logic                  voice_ready;

    // Writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude   <= AMP_RESET;
            r_sample_rate <= RATE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AMPLITUDE:   r_amplitude   <= i_cfg_data[AMP_W-1:0];
                CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: accepts transactions and converts ms into a sample count.
    qtg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_operation   (i_operation),
        .i_phase_step  (i_phase_step),
        .i_duration_ms (i_duration_ms),
        .i_sample_rate (r_sample_rate),
        .i_cmdq_count  (cmd_count),
        .o_cmd_valid   (cmd_push),
        .o_cmd         (cmd_in)
    );

    // Decoupling queue: front and back stall independently.
    qtg_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_head),
        .o_count (cmd_count)
    );

    // Back, part one: note queue bookkeeping and phase accumulation.
    qtg_player u_player (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd_head),
        .o_cmd_pop     (cmd_pop),
        .i_voice_ready (voice_ready),
        .o_voice_valid (voice_valid),
        .o_voice       (voice)
    );

    // Back, part two: sine, amplitude and the result queue.
    qtg_synth u_synth (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_amplitude   (r_amplitude),
        .i_voice_valid (voice_valid),
        .i_voice       (voice),
        .o_voice_ready (voice_ready),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_sample      (o_sample),
        .o_accepted    (o_accepted),
        .o_pending     (o_pending)
    );

endmodule

`default_nettype wire

// ===== src/qtg_checker.sv =====
// ----------------------------------------------------------------------------
// qtg_checker : port-level checks for the tone generator
// Observes the queue ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_checker
    import qtg_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_full,
    input wire logic                       o_empty,
    input wire logic                       i_pop,
    input wire logic signed [SAMPLE_W-1:0] o_sample,
    input wire logic                       o_accepted,
    input wire logic [PEND_W-1:0]          o_pending
);

    // Reset leaves both queues open for business and empty.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty && !o_full)
        else $error("queues not cleared by reset");

    // A stored note gives silence.
    a_enqueue_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_accepted) |-> o_sample == '0)
        else $error("enqueue result carries a sample");

    // Successive results move the note count by at most one.
    a_pending_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop) ##1 !o_empty |->
            (PEND_W'(o_pending - $past(o_pending)) == PEND_W'(0)) ||
            (PEND_W'(o_pending - $past(o_pending)) == PEND_W'(1)) ||
            (PEND_W'($past(o_pending) - o_pending) == PEND_W'(1)))
        else $error("pending jumped between results");

    // A stored note raises the count by exactly one.
    a_accept_bumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop) ##1 !o_empty |->
            !o_accepted || (o_pending == PEND_W'($past(o_pending) + 1'b1)))
        else $error("stored note did not raise pending");

    // A waiting result holds until popped.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> !o_empty && $stable(o_sample)
            && $stable(o_accepted) && $stable(o_pending))
        else $error("waiting result changed");

endmodule

bind queued_tone_generator_unit qtg_checker u_qtg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_full     (o_full),
    .o_empty    (o_empty),
    .i_pop      (i_pop),
    .o_sample   (o_sample),
    .o_accepted (o_accepted),
    .o_pending  (o_pending)
);

`default_nettype wire
